>>> hw/rtl/kmpq_pkg.sv
// ----------------------------------------------------------------------------
// kmpq_pkg
// Shared types and codes for the keyed max-priority queue: request and
// response words, slot layout, operation kinds and status codes.
// ----------------------------------------------------------------------------
package kmpq_pkg;

  localparam int KEY_W  = 16;
  localparam int PRIO_W = 32;

  typedef logic [KEY_W-1:0]         key_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  // operation kinds
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_CHANGE  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_NOKEY = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // request word
  typedef struct packed {
    logic [1:0] kind;
    key_t       key;
    prio_t      priority_req;
  } req_t;

  // response word
  typedef struct packed {
    logic [2:0] status;
    key_t       out_key;
    prio_t      out_priority;
    logic [4:0] occupancy;
  } rsp_t;

  // one queue slot as held in the slot memory
  typedef struct packed {
    logic  used;
    key_t  key;
    prio_t prio;
  } slot_t;

endpackage

>>> hw/rtl/keyed_max_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// keyed_max_priority_queue_unit
// Keyed max-priority queue of CAPACITY slots: insert, extract highest and
// change priority, one response word per request word.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  kmpq_pkg::req_t
//   rsp      out  rsp_valid/rsp_stall  kmpq_pkg::rsp_t
//
// A request passes through accept, a sweep of every slot of the slot memory
// through its one read port into the shared compare unit, a write-back and
// the load of the response register, which waits while an older response stalls.
// After reset a clearing pass over every slot empties the slot memory;
// req_stall stays high during it.
// A stalled response holds; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module keyed_max_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  kmpq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output kmpq_pkg::rsp_t  rsp
);
  import kmpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = AW + 1;
  localparam int NW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_HOLD
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [NW-1:0]   entry_count;
  logic [NW-1:0]   count_next;
  req_t            req_r;
  rsp_t            res;
  rsp_t            res_next;

  // slot memory, one write and one registered read port
  slot_t           mem [CAPACITY];
  slot_t           rd_slot;
  logic            rd_valid;
  logic [AW-1:0]   rd_idx;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  slot_t           wr_data;

  // scan results
  logic            found;
  logic [AW-1:0]   found_idx;
  logic            free_found;
  logic [AW-1:0]   free_idx;
  logic            best_valid;
  logic [AW-1:0]   best_idx;
  key_t            best_key;
  prio_t           best_prio;

  logic            above;
  logic            key_eq;
  logic            scan_last;

  assign req_stall = (state != S_IDLE);
  assign scan_last = (cnt == CW'(CAPACITY));

  // shared compare unit against the running best and the request key
  kmpq_cmp u_cmp (
    .a_key   (rd_slot.key),
    .a_prio  (rd_slot.prio),
    .b_key   (best_key),
    .b_prio  (best_prio),
    .m_key   (req_r.key),
    .a_above (above),
    .key_eq  (key_eq)
  );

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_SCAN && !scan_last) begin
      rd_slot <= mem[cnt[AW-1:0]];
    end
  end

  // write-back and result decode
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = cnt[AW-1:0];
    wr_data    = '0;
    count_next = entry_count;
    res_next   = '0;
    res_next.status = ST_OK;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_WRITE) begin
      case (req_r.kind)
        KIND_INSERT: begin
          if (found) begin
            res_next.status = ST_DUP;
          end else if (!free_found) begin
            res_next.status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = free_idx;
            wr_data    = '{used: 1'b1, key: req_r.key, prio: req_r.priority_req};
            count_next = entry_count + NW'(1);
          end
        end
        KIND_EXTRACT: begin
          if (!best_valid) begin
            res_next.status = ST_EMPTY;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = best_idx;
            wr_data    = '{used: 1'b0, key: best_key, prio: best_prio};
            count_next = (entry_count != '0) ? entry_count - NW'(1) : entry_count;
            res_next.out_key      = best_key;
            res_next.out_priority = best_prio;
          end
        end
        KIND_CHANGE: begin
          if (!found) begin
            res_next.status = ST_NOKEY;
          end else begin
            wr_en   = 1'b1;
            wr_addr = found_idx;
            wr_data = '{used: 1'b1, key: req_r.key, prio: req_r.priority_req};
          end
        end
        default: begin
          res_next.status = ST_OK;
        end
      endcase
    end
    res_next.occupancy = 5'(count_next);
  end

  // sequencer, scan tracking and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      entry_count <= '0;
      rd_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_HOLD)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == CW'(CAPACITY - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_IDLE: begin
          rd_valid   <= 1'b0;
          found      <= 1'b0;
          free_found <= 1'b0;
          best_valid <= 1'b0;
          if (req_valid) begin
            req_r <= req;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= !scan_last;
          rd_idx   <= cnt[AW-1:0];
          if (!scan_last) begin
            cnt <= cnt + CW'(1);
          end else begin
            state <= S_WRITE;
          end
          // evaluate the slot read in the previous cycle
          if (rd_valid) begin
            if (rd_slot.used && key_eq) begin
              found     <= 1'b1;
              found_idx <= rd_idx;
            end
            if (!rd_slot.used && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_slot.used && (!best_valid || above)) begin
              best_valid <= 1'b1;
              best_idx   <= rd_idx;
              best_key   <= rd_slot.key;
              best_prio  <= rd_slot.prio;
            end
          end
        end
        S_WRITE: begin
          entry_count <= count_next;
          res         <= res_next;
          state       <= S_HOLD;
        end
        S_HOLD: begin
          // load when the register is empty or its word leaves this cycle
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a taken request starts a sweep, never a second acceptance
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while a sweep was pending");

  // the entry count never exceeds the slot count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= NW'(CAPACITY))
    else $error("entry count beyond capacity");

  // a failed request returns no entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.out_key == '0) && (rsp.out_priority == '0))
    else $error("error response carries entry data");

  // the count moves only in the write-back cycle
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_WRITE |=> $stable(entry_count))
    else $error("entry count changed outside write-back");

endmodule

>>> hw/rtl/kmpq_cmp.sv
// ----------------------------------------------------------------------------
// kmpq_cmp
// Shared rank and key compare unit: orders two entries as (priority, key)
// pairs with signed priority, and checks the entry key against a lookup key.
// ----------------------------------------------------------------------------
module kmpq_cmp (
  input  kmpq_pkg::key_t  a_key,
  input  kmpq_pkg::prio_t a_prio,
  input  kmpq_pkg::key_t  b_key,
  input  kmpq_pkg::prio_t b_prio,
  input  kmpq_pkg::key_t  m_key,
  output logic            a_above,
  output logic            key_eq
);
  import kmpq_pkg::*;

  // priority first, larger key breaks a tie
  assign a_above = (a_prio > b_prio) || ((a_prio == b_prio) && (a_key > b_key));

  // key match for lookups
  assign key_eq = (a_key == m_key);

endmodule
